// File: hw/rtl/bsta_pkg.sv
package bsta_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W  = 5;
  localparam int VAL_W    = 48;
  localparam int OPND_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int REQ_W    = 3;
  localparam int STAT_W   = 2;
  localparam int PROD_W   = VAL_W + OPND_W;
  localparam int MUL_STEPS = OPND_W;
  localparam int DIV_STEPS = VAL_W;
  localparam int STEP_W   = $clog2(DIV_STEPS);

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH = 3'd0,
    REQ_POP  = 3'd1,
    REQ_ADD  = 3'd2,
    REQ_SUB  = 3'd3,
    REQ_MUL  = 3'd4,
    REQ_DIV  = 3'd5
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_DIVZERO = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_DONE
  } stack_state_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_RUN,
    A_FIN
  } alu_state_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } alu_op_t;

  typedef struct packed {
    logic                     start;
    alu_op_t                  op;
    logic signed [VAL_W-1:0]  a;
    logic signed [OPND_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] result;
  } alu_rsp_t;

endpackage

// File: hw/rtl/bsta_alu.sv
module bsta_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  bsta_pkg::alu_req_t req,
  output bsta_pkg::alu_rsp_t rsp
);

  localparam int VW = bsta_pkg::VAL_W;
  localparam int OW = bsta_pkg::OPND_W;
  localparam int PW = bsta_pkg::PROD_W;
  localparam int SW = bsta_pkg::STEP_W;

  bsta_pkg::alu_state_t state_r, state_nxt;
  bsta_pkg::alu_op_t    op_r, op_nxt;
  logic [PW-1:0]        acc_r, acc_nxt;
  logic [VW-1:0]        ma_r, ma_nxt;
  logic [OW-1:0]        mb_r, mb_nxt;
  logic                 neg_r, neg_nxt;
  logic [SW-1:0]        cnt_r, cnt_nxt;

  logic [VW-1:0] ma_in;
  logic [OW-1:0] mb_in;
  logic [VW:0]   add_x, add_y;
  logic          add_sub;
  logic [VW+1:0] add_s;
  logic          div_ok;
  logic [OW-1:0] rem_nxt;
  logic [PW-1:0] mag;
  logic [PW-1:0] lim;
  logic [VW-1:0] mag_sat;

  assign ma_in = req.a[VW-1] ? VW'(-req.a) : VW'(req.a);
  assign mb_in = req.b[OW-1] ? OW'(-req.b) : OW'(req.b);

  // shared adder: accumulate for multiply, trial subtract for divide
  always_comb begin
    if (op_r == bsta_pkg::OP_MUL) begin
      add_x   = {1'b0, acc_r[PW-1:OW]};
      add_y   = acc_r[0] ? {1'b0, ma_r} : '0;
      add_sub = 1'b0;
    end else begin
      add_x   = (VW+1)'({acc_r[PW-2:VW-1]});
      add_y   = (VW+1)'(mb_r);
      add_sub = 1'b1;
    end
    add_s = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (VW+2)'(add_sub);
  end

  assign div_ok  = add_s[VW+1];
  assign rem_nxt = div_ok ? add_s[OW-1:0] : acc_r[PW-2:VW-1];

  assign mag = (op_r == bsta_pkg::OP_MUL) ? acc_r : PW'(acc_r[VW-1:0]);
  assign lim = neg_r ? PW'({1'b1, {(VW-1){1'b0}}}) : PW'({1'b0, {(VW-1){1'b1}}});
  assign mag_sat = (mag > lim) ? lim[VW-1:0] : mag[VW-1:0];

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    acc_nxt   = acc_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    rsp.done   = 1'b0;
    rsp.result = neg_r ? VW'(-mag_sat) : mag_sat;
    unique case (state_r)
      bsta_pkg::A_IDLE: begin
        if (req.start) begin
          op_nxt  = req.op;
          ma_nxt  = ma_in;
          mb_nxt  = mb_in;
          neg_nxt = req.a[VW-1] ^ req.b[OW-1];
          if (req.op == bsta_pkg::OP_MUL) begin
            acc_nxt = PW'(mb_in);
            cnt_nxt = SW'(bsta_pkg::MUL_STEPS - 1);
          end else begin
            acc_nxt = PW'(ma_in);
            cnt_nxt = SW'(bsta_pkg::DIV_STEPS - 1);
          end
          state_nxt = bsta_pkg::A_RUN;
        end
      end
      bsta_pkg::A_RUN: begin
        if (op_r == bsta_pkg::OP_MUL) begin
          acc_nxt = {add_s[VW:0], acc_r[OW-1:1]};
        end else begin
          acc_nxt = {rem_nxt, acc_r[VW-2:0], div_ok};
        end
        if (cnt_r == '0) begin
          state_nxt = bsta_pkg::A_FIN;
        end else begin
          cnt_nxt = cnt_r - SW'(1);
        end
      end
      bsta_pkg::A_FIN: begin
        rsp.done  = 1'b1;
        state_nxt = bsta_pkg::A_IDLE;
      end
      default: state_nxt = bsta_pkg::A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsta_pkg::A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

// File: hw/rtl/bounded_stack_with_top_alu_top.sv
// Bounded LIFO stack of 16 signed Q31.16 entries with arithmetic on the top entry.
// Input channel (in_valid/in_ready): one request word of in_req_type and
// in_operand. Push stores operand * 2^16, pop removes the top entry, and
// add, subtract, multiply and divide update the top entry in place.
// Result channel (out_valid/out_ready): one word per request with out_status,
// out_popped_value (zero unless a pop succeeds) and out_entry_count.
// Push, pop, add, subtract, refused requests and unused codes complete without
// the ALU; multiply and divide wait in S_WAIT until the ALU reports done.
// Multiply and divide run on one shared 49-bit adder, one bit per cycle
// (32 multiplier bits, 48 quotient bits); that loop sets the item time.
// Only one request is in flight: in_ready is high while the block is idle,
// also while a finished word still waits in the output register.
// When the receiver stalls, the next result holds in the block until the
// output register frees up. Reset (rst_n low, synchronous) empties the
// stack and drops any pending word; entry contents are not cleared.
module bounded_stack_with_top_alu_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bsta_pkg::REQ_W-1:0]          in_req_type,
  input  logic signed [bsta_pkg::OPND_W-1:0]  in_operand,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bsta_pkg::STAT_W-1:0]         out_status,
  output logic signed [bsta_pkg::VAL_W-1:0]   out_popped_value,
  output logic [bsta_pkg::ENTRY_W-1:0]        out_entry_count
);

  localparam int VW = bsta_pkg::VAL_W;
  localparam int OW = bsta_pkg::OPND_W;
  localparam int FW = bsta_pkg::FILL_W;
  localparam int IW = bsta_pkg::IDX_W;

  logic signed [VW-1:0] mem [bsta_pkg::DEPTH];

  bsta_pkg::stack_state_t state_r, state_nxt;
  bsta_pkg::req_t         req_r, req_nxt;
  logic signed [OW-1:0]   opnd_r, opnd_nxt;
  logic [FW-1:0]          fill_r, fill_nxt;
  bsta_pkg::status_t      status_r, status_nxt;
  logic signed [VW-1:0]   pop_r, pop_nxt;
  logic                   out_valid_r, out_valid_nxt;
  bsta_pkg::status_t      out_status_r, out_status_nxt;
  logic signed [VW-1:0]   out_pop_r, out_pop_nxt;
  logic [FW-1:0]          out_fill_r, out_fill_nxt;
  logic signed [VW-1:0]   rd_data_r;

  logic                 wr_en;
  logic [IW-1:0]        wr_idx;
  logic signed [VW-1:0] wr_data;
  logic [IW-1:0]        top_idx;
  logic                 is_full, is_empty;
  logic signed [VW-1:0] scaled;
  logic signed [VW:0]   addsub;
  logic signed [VW-1:0] addsub_sat;

  bsta_pkg::alu_req_t alu_req;
  bsta_pkg::alu_rsp_t alu_rsp;

  bsta_alu u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (alu_req),
    .rsp  (alu_rsp)
  );

  assign top_idx  = IW'(fill_r - FW'(1));
  assign is_full  = (fill_r >= FW'(bsta_pkg::DEPTH));
  assign is_empty = (fill_r == '0);
  assign scaled   = {opnd_r, {bsta_pkg::FRAC_W{1'b0}}};

  always_comb begin
    if (req_r == bsta_pkg::REQ_SUB) begin
      addsub = {rd_data_r[VW-1], rd_data_r} - {scaled[VW-1], scaled};
    end else begin
      addsub = {rd_data_r[VW-1], rd_data_r} + {scaled[VW-1], scaled};
    end
    if (addsub[VW] != addsub[VW-1]) begin
      addsub_sat = addsub[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else begin
      addsub_sat = addsub[VW-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    opnd_nxt       = opnd_r;
    fill_nxt       = fill_r;
    status_nxt     = status_r;
    pop_nxt        = pop_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_pop_nxt    = out_pop_r;
    out_fill_nxt   = out_fill_r;
    wr_en          = 1'b0;
    wr_idx         = top_idx;
    wr_data        = alu_rsp.result;
    alu_req.start  = 1'b0;
    alu_req.op     = (req_r == bsta_pkg::REQ_DIV) ? bsta_pkg::OP_DIV : bsta_pkg::OP_MUL;
    alu_req.a      = rd_data_r;
    alu_req.b      = opnd_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      bsta_pkg::S_IDLE: begin
        if (in_valid) begin
          req_nxt   = bsta_pkg::req_t'(in_req_type);
          opnd_nxt  = in_operand;
          state_nxt = bsta_pkg::S_EXEC;
        end
      end
      bsta_pkg::S_EXEC: begin
        status_nxt = bsta_pkg::ST_OK;
        pop_nxt    = '0;
        state_nxt  = bsta_pkg::S_DONE;
        priority if (req_r == bsta_pkg::REQ_PUSH) begin
          if (is_full) begin
            status_nxt = bsta_pkg::ST_FULL;
          end else begin
            wr_en    = 1'b1;
            wr_idx   = fill_r[IW-1:0];
            wr_data  = scaled;
            fill_nxt = fill_r + FW'(1);
          end
        end else if (req_r == bsta_pkg::REQ_POP || req_r == bsta_pkg::REQ_ADD ||
                     req_r == bsta_pkg::REQ_SUB || req_r == bsta_pkg::REQ_MUL ||
                     req_r == bsta_pkg::REQ_DIV) begin
          priority if (is_empty) begin
            status_nxt = bsta_pkg::ST_EMPTY;
          end else if (req_r == bsta_pkg::REQ_POP) begin
            pop_nxt  = rd_data_r;
            fill_nxt = fill_r - FW'(1);
          end else if (req_r == bsta_pkg::REQ_ADD || req_r == bsta_pkg::REQ_SUB) begin
            wr_en   = 1'b1;
            wr_data = addsub_sat;
          end else if (req_r == bsta_pkg::REQ_DIV && opnd_r == '0) begin
            status_nxt = bsta_pkg::ST_DIVZERO;
          end else begin
            alu_req.start = 1'b1;
            state_nxt     = bsta_pkg::S_WAIT;
          end
        end else begin
          status_nxt = bsta_pkg::ST_OK;
        end
      end
      bsta_pkg::S_WAIT: begin
        if (alu_rsp.done) begin
          wr_en     = 1'b1;
          state_nxt = bsta_pkg::S_DONE;
        end
      end
      bsta_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_pop_nxt    = pop_r;
          out_fill_nxt   = fill_r;
          state_nxt      = bsta_pkg::S_IDLE;
        end
      end
      default: state_nxt = bsta_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsta_pkg::S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    opnd_r       <= opnd_nxt;
    status_r     <= status_nxt;
    pop_r        <= pop_nxt;
    out_status_r <= out_status_nxt;
    out_pop_r    <= out_pop_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data_r <= mem[top_idx];
  end

  assign in_ready         = (state_r == bsta_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_pop_r;
  assign out_entry_count  = bsta_pkg::ENTRY_W'(out_fill_r);

endmodule
